@@ hdl/mlbd_pkg.sv @@
// Shared types and constants for the mip level box downsampler.
`timescale 1ns / 1ps

package mlbd_pkg;

  // Largest source width that the line store covers.
  localparam int MAX_WIDTH  = 4096;
  localparam int LINE_DEPTH = MAX_WIDTH / 2;

  localparam int NUM_CHAN   = 4;
  localparam int CHAN_W     = 8;
  localparam int SUM_W      = CHAN_W + 1;   // one horizontal pair sum
  localparam int BLK_W      = CHAN_W + 2;   // one 2x2 block sum

  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ADDR_W     = $clog2(LINE_DEPTH);
  localparam int ROW_W      = 16;
  localparam int TY_W       = ROW_W - 1;
  localparam int CFG_WIDTH_W = 13;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_HEIGHT = CFG_IDX_W'(1);

  typedef logic [NUM_CHAN-1:0][CHAN_W-1:0] pixel_t;
  typedef logic [NUM_CHAN-1:0][SUM_W-1:0]  pair_t;

endpackage

@@ hdl/mlbd_line_store.sv @@
// Line store holding the horizontal pair sums of the even source row.
`timescale 1ns / 1ps

module mlbd_line_store (
  input  logic                        clk,
  input  logic                        wr_en,
  input  logic [mlbd_pkg::ADDR_W-1:0] wr_addr,
  input  mlbd_pkg::pair_t             wr_data,
  input  logic                        rd_en,
  input  logic [mlbd_pkg::ADDR_W-1:0] rd_addr,
  output mlbd_pkg::pair_t             rd_data
);
  import mlbd_pkg::*;

  pair_t mem [LINE_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read data holds until the next read.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ hdl/mip_level_box_downsample.sv @@
// Top level of the mip level 2x2 box downsampler.
`timescale 1ns / 1ps

//  channel   direction  handshake              payload
//  --------  ---------  ---------------------  -----------------------------------
//  in        sink       in_valid / in_ready    chan_blue, chan_green, chan_red,
//                                              chan_alpha
//  out       source     out_valid / out_ready  out_blue, out_green, out_red,
//                                              out_alpha, last_pixel
//  cfg       sink       cfg_write (no wait)    cfg_index, cfg_data
//
//  One source pixel per cycle sustained. A result goes from the transfer that
//  completes its 2x2 block through the block stage, which covers the line store's
//  registered read, and the output register. Reset is synchronous and restores
//  2x2 geometry; the line store needs no clearing, since odd rows only read what
//  the even row above wrote. A held output and a full block stage drop in_ready;
//  otherwise in_ready stays high. A config write restarts the frame.

module mip_level_box_downsample (
  input  logic                           clk,
  input  logic                           rst,

  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [7:0]                     chan_blue,
  input  logic [7:0]                     chan_green,
  input  logic [7:0]                     chan_red,
  input  logic [7:0]                     chan_alpha,

  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [7:0]                     out_blue,
  output logic [7:0]                     out_green,
  output logic [7:0]                     out_red,
  output logic [7:0]                     out_alpha,
  output logic                           last_pixel,

  input  logic                           cfg_write,
  input  logic [mlbd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mlbd_pkg::CFG_DATA_W-1:0] cfg_data
);
  import mlbd_pkg::*;

  // Geometry, precomputed at config write time.
  logic [COL_W-1:0]  w_m1;       // effective width - 1
  logic              w_one;      // width clamps to one column
  logic [ADDR_W-1:0] tx_last;    // last target column
  logic [ROW_W-1:0]  h_m1;       // effective height - 1
  logic              h_one;
  logic [TY_W-1:0]   ty_last;

  // Frame position and the even-column pixel waiting for its partner.
  logic [COL_W-1:0]  col_count;
  logic [ROW_W-1:0]  row_count;
  pixel_t            pending;

  // Block stage: pair sum waiting for the line store read.
  logic              s1_valid;
  pair_t             s1_pair;
  logic              s1_dbl;     // single-row source: pair counts twice
  logic              s1_last;

  pair_t             above;

  // Config decode
  logic [CFG_WIDTH_W-1:0] w_raw;
  logic [CFG_WIDTH_W-1:0] w_eff;
  logic [ROW_W-1:0]       h_raw;
  logic [ROW_W-1:0]       h_eff;

  always_comb begin
    w_raw = cfg_data[CFG_WIDTH_W-1:0];
    w_eff = w_raw;
    if (w_raw == '0) begin
      w_eff = CFG_WIDTH_W'(1);
    end else if (int'(w_raw) > MAX_WIDTH) begin
      w_eff = CFG_WIDTH_W'(MAX_WIDTH);
    end
    h_raw = cfg_data[ROW_W-1:0];
    h_eff = (h_raw == '0) ? ROW_W'(1) : h_raw;
  end

  // Input side
  logic              accept;
  pixel_t            px;
  pair_t             pr;
  logic              have_pair;
  logic [ADDR_W-1:0] tx;
  logic [TY_W-1:0]   ty;
  logic              line_wr;
  logic              line_rd;
  logic              emit;
  logic              col_end;
  logic              out_room;
  logic              out_take;

  assign out_room = !out_valid || out_ready;
  assign out_take = s1_valid && out_room;
  assign in_ready = !s1_valid || out_room;
  assign accept   = in_valid && in_ready;

  assign px = {chan_alpha, chan_red, chan_green, chan_blue};

  always_comb begin
    for (int i = 0; i < NUM_CHAN; i++) begin
      if (w_one) begin
        pr[i] = {px[i], 1'b0};
      end else begin
        pr[i] = {1'b0, pending[i]} + {1'b0, px[i]};
      end
    end
    have_pair = w_one || col_count[0];
    tx        = w_one ? '0 : col_count[COL_W-1:1];
    ty        = h_one ? '0 : row_count[ROW_W-1:1];
    line_wr   = accept && have_pair && !h_one && !row_count[0];
    line_rd   = accept && have_pair && !h_one && row_count[0];
    emit      = have_pair && (h_one || row_count[0]);
    col_end   = (col_count == w_m1);
  end

  mlbd_line_store u_line_store (
    .clk     (clk),
    .wr_en   (line_wr),
    .wr_addr (tx),
    .wr_data (pr),
    .rd_en   (line_rd),
    .rd_addr (tx),
    .rd_data (above)
  );

  // Geometry and frame position
  always_ff @(posedge clk) begin
    if (rst) begin
      w_m1      <= COL_W'(1);
      w_one     <= 1'b0;
      tx_last   <= '0;
      h_m1      <= ROW_W'(1);
      h_one     <= 1'b0;
      ty_last   <= '0;
      col_count <= '0;
      row_count <= '0;
      pending   <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_SOURCE_WIDTH: begin
          w_m1    <= COL_W'(w_eff - CFG_WIDTH_W'(1));
          w_one   <= (w_eff == CFG_WIDTH_W'(1));
          tx_last <= (w_eff == CFG_WIDTH_W'(1)) ? '0
                                               : ADDR_W'((w_eff >> 1) - CFG_WIDTH_W'(1));
        end
        REG_SOURCE_HEIGHT: begin
          h_m1    <= h_eff - ROW_W'(1);
          h_one   <= (h_eff == ROW_W'(1));
          ty_last <= (h_eff == ROW_W'(1)) ? '0 : TY_W'((h_eff >> 1) - ROW_W'(1));
        end
        default: ;
      endcase
      // any write restarts the frame
      col_count <= '0;
      row_count <= '0;
      pending   <= '0;
    end else if (accept) begin
      if (!w_one && !col_count[0] && !col_end) begin
        pending <= px;
      end
      if (col_end) begin
        col_count <= '0;
        row_count <= (row_count == h_m1) ? '0 : row_count + ROW_W'(1);
      end else begin
        col_count <= col_count + COL_W'(1);
      end
    end
  end

  // Block stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept && emit) begin
      s1_valid <= 1'b1;
    end else if (out_take) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      s1_pair <= pr;
      s1_dbl  <= h_one;
      s1_last <= (tx == tx_last) && (ty == ty_last);
    end
  end

  // Block sum and rounded mean
  logic [NUM_CHAN-1:0][BLK_W-1:0]  blk;
  logic [NUM_CHAN-1:0][CHAN_W-1:0] mean;

  always_comb begin
    for (int i = 0; i < NUM_CHAN; i++) begin
      if (s1_dbl) begin
        blk[i] = {s1_pair[i], 1'b0};
      end else begin
        blk[i] = {1'b0, above[i]} + {1'b0, s1_pair[i]};
      end
      mean[i] = 8'((blk[i] + BLK_W'(2)) >> 2);
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_take) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_take) begin
      out_blue   <= mean[0];
      out_green  <= mean[1];
      out_red    <= mean[2];
      out_alpha  <= mean[3];
      last_pixel <= s1_last;
    end
  end

  // Checks
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && out_valid && !out_ready) |-> !in_ready)
    else $error("input taken while block stage and output are both held");

  a_col_in_range: assert property (@(posedge clk) disable iff (rst)
    col_count <= w_m1)
    else $error("column count beyond source width");

  a_row_in_range: assert property (@(posedge clk) disable iff (rst)
    row_count <= h_m1)
    else $error("row count beyond source height");

  a_block_stage_moves: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && out_room && !(accept && emit)) |=> !s1_valid)
    else $error("block stage kept a result that had room to move");

endmodule

@@ sim/mip_level_box_downsample_tb.sv @@
// Self-checking testbench for the mip level 2x2 box downsampler.
`timescale 1ns / 1ps

// One target pixel: per-channel rounded block mean plus the end-of-level flag.
typedef struct packed {
  mlbd_pkg::pixel_t mean;
  logic             last;
} target_px_t;

// Scoreboard: tracks the frame position and the line of pair sums, predicts
// each target pixel as source pixels are accepted, and checks what comes out.
class box_average_board;
  logic [mlbd_pkg::CFG_WIDTH_W-1:0] width_reg;
  logic [mlbd_pkg::ROW_W-1:0]       height_reg;
  int unsigned                      col;
  int unsigned                      row;
  mlbd_pkg::pixel_t                 left_px;
  mlbd_pkg::pair_t                  sum_line [mlbd_pkg::LINE_DEPTH];
  target_px_t                       targets_due [$];
  int unsigned                      errors;
  int unsigned                      n_pixels;
  int unsigned                      n_targets;

  function new();
    width_reg  = mlbd_pkg::CFG_WIDTH_W'(2);
    height_reg = mlbd_pkg::ROW_W'(2);
    col        = 0;
    row        = 0;
    left_px    = '0;
    errors     = 0;
    n_pixels   = 0;
    n_targets  = 0;
  endfunction

  function int unsigned eff_width();
    if (width_reg == 0) return 1;
    if (width_reg > mlbd_pkg::MAX_WIDTH) return mlbd_pkg::MAX_WIDTH;
    return 32'(width_reg);
  endfunction

  function int unsigned eff_height();
    return (height_reg == 0) ? 1 : 32'(height_reg);
  endfunction

  // Any register write restarts the frame.
  function void write_reg(logic [mlbd_pkg::CFG_IDX_W-1:0] idx,
                          logic [mlbd_pkg::CFG_DATA_W-1:0] data);
    if (idx == mlbd_pkg::REG_SOURCE_WIDTH) width_reg = data[mlbd_pkg::CFG_WIDTH_W-1:0];
    else height_reg = data;
    col     = 0;
    row     = 0;
    left_px = '0;
  endfunction

  // Accepted source pixel: advance the frame and queue a target if it completes one.
  function void take_pixel(mlbd_pkg::pixel_t px);
    int unsigned                w;
    int unsigned                h;
    int unsigned                tx;
    int unsigned                ty;
    int unsigned                tw;
    int unsigned                th;
    bit                         have_pair;
    bit                         fire;
    mlbd_pkg::pair_t            pr;
    mlbd_pkg::pair_t            above;
    logic [mlbd_pkg::BLK_W-1:0] bsum;
    target_px_t                 res;
    w         = eff_width();
    h         = eff_height();
    have_pair = 1'b0;
    fire      = 1'b0;
    pr        = '0;
    res       = '0;
    tx        = 0;
    n_pixels++;
    if (w == 1) begin
      // single column: the pixel pairs with itself
      for (int i = 0; i < mlbd_pkg::NUM_CHAN; i++) pr[i] = {px[i], 1'b0};
      have_pair = 1'b1;
    end else if (col % 2 == 0) begin
      if (col + 1 < w) left_px = px;
    end else begin
      for (int i = 0; i < mlbd_pkg::NUM_CHAN; i++)
        pr[i] = {1'b0, left_px[i]} + {1'b0, px[i]};
      have_pair = 1'b1;
    end
    if (have_pair) begin
      tx = (w == 1) ? 0 : col / 2;
      if (h == 1) begin
        for (int i = 0; i < mlbd_pkg::NUM_CHAN; i++) begin
          bsum = {pr[i], 1'b0};
          bsum = bsum + mlbd_pkg::BLK_W'(2);
          res.mean[i] = bsum[mlbd_pkg::BLK_W-1:2];
        end
        fire = 1'b1;
      end else if (row % 2 == 0) begin
        sum_line[tx] = pr;
      end else begin
        above = sum_line[tx];
        for (int i = 0; i < mlbd_pkg::NUM_CHAN; i++) begin
          bsum = {1'b0, above[i]};
          bsum = bsum + {1'b0, pr[i]} + mlbd_pkg::BLK_W'(2);
          res.mean[i] = bsum[mlbd_pkg::BLK_W-1:2];
        end
        fire = 1'b1;
      end
    end
    if (fire) begin
      tw       = (w >= 2) ? w / 2 : 1;
      th       = (h >= 2) ? h / 2 : 1;
      ty       = (h == 1) ? 0 : row / 2;
      res.last = (tx + 1 == tw) && (ty + 1 == th);
      targets_due = {targets_due, res};
    end
    col++;
    if (col >= w) begin
      col = 0;
      row++;
      if (row >= h) row = 0;
    end
  endfunction

  task report(string what);
    errors++;
    if (errors <= 40) $display("[%0t] MISMATCH: %s", $time, what);
  endtask

  task match_target(target_px_t got);
    target_px_t want;
    string      chan_name [mlbd_pkg::NUM_CHAN];
    chan_name = '{"blue", "green", "red", "alpha"};
    if (targets_due.size() == 0) begin
      report($sformatf("target pixel with none expected (blue %0d last %0b)",
                       got.mean[0], got.last));
      return;
    end
    want = targets_due.pop_front();
    n_targets++;
    for (int i = 0; i < mlbd_pkg::NUM_CHAN; i++)
      if (got.mean[i] !== want.mean[i])
        report($sformatf("target %0d out_%s got %0d want %0d", n_targets, chan_name[i],
                         got.mean[i], want.mean[i]));
    if (got.last !== want.last)
      report($sformatf("target %0d last_pixel got %0b want %0b", n_targets, got.last,
                       want.last));
  endtask
endclass

module mip_level_box_downsample_tb;
  import mlbd_pkg::*;

  // Run length and pacing knobs.
  localparam int RANDOM_PIXELS = 1650;
  localparam int HOLD_CYCLES   = 300;   // long receiver hold-off
  localparam int SETTLE_CYCLES = 8;     // covers pixels in flight that yield no target
  localparam int DRAIN_CYCLES  = 5000;
  localparam int LIMIT_CYCLES  = 400000;
  localparam int IDLE_PCT      = 8;

  logic                  clk        = 1'b0;
  logic                  rst        = 1'b1;
  logic                  in_valid   = 1'b0;
  logic                  in_ready;
  logic [7:0]            chan_blue  = '0;
  logic [7:0]            chan_green = '0;
  logic [7:0]            chan_red   = '0;
  logic [7:0]            chan_alpha = '0;
  logic                  out_valid;
  logic                  out_ready  = 1'b0;
  logic [7:0]            out_blue;
  logic [7:0]            out_green;
  logic [7:0]            out_red;
  logic [7:0]            out_alpha;
  logic                  last_pixel;
  logic                  cfg_write  = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [CFG_DATA_W-1:0] cfg_data   = '0;

  box_average_board board = new();

  bit          steady       = 1'b0;  // both sides run without idling while set
  bit          hold_request = 1'b0;  // asks the receiver for one long hold-off
  int unsigned cycle_count  = 0;
  int unsigned geometries   = 0;

  mip_level_box_downsample i_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .chan_blue  (chan_blue),
    .chan_green (chan_green),
    .chan_red   (chan_red),
    .chan_alpha (chan_alpha),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_blue   (out_blue),
    .out_green  (out_green),
    .out_red    (out_red),
    .out_alpha  (out_alpha),
    .last_pixel (last_pixel),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // 100 MHz clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  // Watchdog: a hang anywhere ends the run here.
  initial begin
    wait (cycle_count >= LIMIT_CYCLES);
    $display("timeout after %0d cycles, %0d target pixels still due", cycle_count,
             board.targets_due.size());
    $display("CHECKS FAILED");
    $finish;
  end

  // Receiver. Everything is sampled at the rising edge, before the NBA updates
  // land, so a transfer here is exactly what the block saw. Ready idles at
  // random, except in the steady window, and once drops for a long hold-off so
  // the block backs up and stalls its input.
  int unsigned hold_left = 0;
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready)
        board.match_target({{out_alpha, out_red, out_green, out_blue}, last_pixel});
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = HOLD_CYCLES;
        out_ready    <= 1'b0;
      end else begin
        out_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  function automatic pixel_t pix(input logic [7:0] b, g, r, a);
    return {a, r, g, b};
  endfunction

  // Offer one source pixel, maybe after random idling, and hold it until
  // the transfer. The scoreboard learns of it at the accepting edge.
  task automatic send_pixel(input pixel_t px);
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    chan_blue  <= px[0];
    chan_green <= px[1];
    chan_red   <= px[2];
    chan_alpha <= px[3];
    do @(posedge clk); while (!in_ready);
    board.take_pixel(px);
  endtask

  // Stop offering and let every due target drain; then give pixels that make
  // no target time to leave the pipeline before any register write.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (board.targets_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write both size registers on consecutive edges; each write restarts the frame.
  task automatic set_geometry(input logic [CFG_DATA_W-1:0] w, input logic [CFG_DATA_W-1:0] h);
    cfg_write <= 1'b1;
    cfg_index <= REG_SOURCE_WIDTH;
    cfg_data  <= w;
    @(posedge clk);
    board.write_reg(REG_SOURCE_WIDTH, w);
    cfg_index <= REG_SOURCE_HEIGHT;
    cfg_data  <= h;
    @(posedge clk);
    board.write_reg(REG_SOURCE_HEIGHT, h);
    cfg_write <= 1'b0;
    geometries++;
  endtask

  initial begin
    int unsigned           n;
    int unsigned           frame;
    int unsigned           random_pixels;
    int unsigned           drain;
    int unsigned           sel;
    logic [CFG_DATA_W-1:0] wr;
    logic [CFG_DATA_W-1:0] hr;
    random_pixels = 0;

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset geometry is 2x2: one target. Blue all 255, green all 0, red sums
    // to 2 (rounds up to 1), alpha sums to 1 (rounds down to 0).
    send_pixel(pix(8'd255, 8'd0, 8'd1, 8'd1));
    send_pixel(pix(8'd255, 8'd0, 8'd1, 8'd0));
    send_pixel(pix(8'd255, 8'd0, 8'd0, 8'd0));
    send_pixel(pix(8'd255, 8'd0, 8'd0, 8'd0));
    wait_idle();

    // Zero sizes act as 1x1: each pixel is its own target, counted four times.
    set_geometry(16'd0, 16'd0);
    send_pixel(pix(8'd255, 8'd255, 8'd255, 8'd255));
    send_pixel(pix(8'h80, 8'h7f, 8'h01, 8'hfe));
    wait_idle();

    // 3x3: last column and row dropped, the only target comes mid-frame;
    // the frame then wraps.
    set_geometry(16'd3, 16'd3);
    repeat (9) send_pixel(pixel_t'($urandom));
    wait_idle();

    // Width beyond the line store saturates; one row means vertical clamping.
    set_geometry(16'h1fff, 16'd1);
    repeat (4) send_pixel(pixel_t'($urandom));
    wait_idle();

    // Single column over three rows: horizontal clamping and a dropped last row.
    set_geometry(16'd1, 16'd3);
    repeat (3) send_pixel(pixel_t'($urandom));
    wait_idle();

    // Back-pressure: every pixel makes a target while the receiver holds off
    // for a long stretch, so the block fills and stalls the sender.
    set_geometry(16'd1, 16'd1);
    hold_request = 1'b1;
    repeat (80) send_pixel(pixel_t'($urandom));
    wait_idle();

    // Random geometries. Most are small whole frames, one to three of them,
    // sometimes cut short by the next register write; the extremes show up
    // as short partial frames.
    while (random_pixels < RANDOM_PIXELS) begin
      sel = $urandom_range(19);
      if (sel < 10)       wr = CFG_DATA_W'($urandom_range(8, 1));
      else if (sel < 15)  wr = CFG_DATA_W'($urandom_range(48, 9));
      else if (sel == 15) wr = 16'd0;
      else if (sel == 16) wr = CFG_DATA_W'(MAX_WIDTH);
      else if (sel == 17) wr = CFG_DATA_W'($urandom_range(8191, MAX_WIDTH + 1));
      else if (sel == 18) wr = 16'he000 | CFG_DATA_W'($urandom_range(6, 1));  // high bits ignored
      else                wr = CFG_DATA_W'($urandom_range(2, 1));
      sel = $urandom_range(19);
      if (sel < 12)       hr = CFG_DATA_W'($urandom_range(8, 1));
      else if (sel < 16)  hr = CFG_DATA_W'($urandom_range(40, 9));
      else if (sel == 16) hr = 16'd0;
      else if (sel == 17) hr = 16'hffff;
      else if (sel == 18) hr = CFG_DATA_W'($urandom);
      else                hr = 16'd1;
      set_geometry(wr, hr);

      frame = board.eff_width() * board.eff_height();
      if (frame <= 240) begin
        n = frame * $urandom_range(3, 1);
        if ($urandom_range(3) == 0) n = n + $urandom_range(frame - 1, 0);
      end else begin
        n = $urandom_range(200, 16);
      end

      // One long window with no idling on either side.
      steady = (random_pixels >= 600) && (random_pixels < 1000);
      repeat (n) send_pixel(pixel_t'($urandom));
      random_pixels += n;
      wait_idle();
    end
    steady = 1'b0;

    // Final drain, bounded; anything still due is a miss.
    in_valid <= 1'b0;
    drain = 0;
    while (board.targets_due.size() != 0 && drain < DRAIN_CYCLES) begin
      @(posedge clk);
      drain++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (board.targets_due.size() != 0)
      board.report($sformatf("%0d target pixels never arrived", board.targets_due.size()));

    $display("Run: %0d source pixels over %0d geometries, %0d target pixels compared,",
             board.n_pixels, geometries, board.n_targets);
    $display("     including clamped, saturated, odd and zero sizes and a long output stall.");
    if (board.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
